>>> design/tdps_pkg.sv
// Shared types and constants of the time-of-day pump scheduler.
package tdps_pkg;

	localparam int DEF_ENTRIES = 8;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 72;

	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_START = 2'd1;
	localparam logic [1:0] EV_STOP  = 2'd2;

	localparam logic [1:0] NXT_NONE  = 2'd0;
	localparam logic [1:0] NXT_FOUND = 2'd1;
	localparam logic [1:0] NXT_OFF   = 2'd2;

	localparam logic [10:0]        MIN_PER_HOUR = 11'd60;
	localparam logic signed [12:0] MIN_PER_DAY  = 13'sd1440;
	localparam logic signed [12:0] DIFF_NONE    = 13'sd1441;
	localparam logic [7:0]         NO_MINUTE    = 8'hFF;
	localparam logic [25:0]        MS_PER_SEC   = 26'd1000;

	typedef struct packed {
		logic        active;
		logic [15:0] seconds;
		logic [5:0]  minute;
		logic [4:0]  hour;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} st_t;

endpackage

>>> design/time_of_day_pump_scheduler.sv
// Top level of the time-of-day pump scheduler: entry table memory and scan sequencer.
//
// Usage: commands enter on the s_ stream (tuser holds the command code), one result per
// command leaves on the m_ stream. The enable register is written through cfg_we and
// cfg_wdata while no command is in flight.
// A write command stores its entry in the table at the transfer edge. Every command then
// sweeps the table one entry a cycle through the single read port of the memory; the
// sweep counts enabled entries, finds the nearest future entry, picks the starting entry
// on a tick and captures the entry of a read command.
// The result is registered in DONE after the SCAN and DRAIN states; one command is in
// work at a time, so a new command is taken only after the previous result is loaded,
// at a pace set by the one-entry-a-cycle sweep of the table memory.
// The result sits in an output register; the next command is taken while it waits.
// When the receiver stalls with a result still held, a finished sweep holds until the
// register is free, and s_tready stays low meanwhile.
// Reset: the table reads as all zero and disabled (per-entry valid flops), the block is
// disabled, no watering runs and no minute has been checked yet. No clearing pass.
module time_of_day_pump_scheduler #(
	parameter int ENTRIES = tdps_pkg::DEF_ENTRIES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic                             cfg_wdata,   // scheduler_enable
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// time_ms, time_valid, now_hour, now_minute, soil_needs_water, slot, slot_hour,
	// slot_minute, slot_seconds, slot_active, zero fill
	input  logic [tdps_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [1:0]                       s_tuser,     // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// pump_event, pump_seconds, watering, next_status, next_hour, next_minute,
	// enabled_count, index_ok, read_hour, read_minute, read_seconds, read_active, zero fill
	output logic [tdps_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	tdps_pkg::st_t state_q, state_nx;

	tdps_pkg::entry_t mem [ENTRIES];
	logic [ENTRIES-1:0] entry_vld_q;

	logic             cfg_en_q;
	logic             busy_q;
	logic [31:0]      start_q;
	logic [25:0]      run_ms_q;
	logic [7:0]       last_min_q;

	logic [1:0]       cmd_q;
	logic [31:0]      time_q;
	logic [4:0]       hr_q;
	logic [5:0]       mn_q;
	logic             dry_q;
	logic [7:0]       slot_q;
	logic             ok_q;
	logic [10:0]      cur_q;
	logic             match_en_q;
	logic             stop_chk_q;

	logic [AW-1:0]    rd_addr_q;
	logic             vld_s1;
	logic             rvld_s1;
	logic [AW-1:0]    idx_s1;
	tdps_pkg::entry_t rd_data_s1;

	logic [CW-1:0]    cnt_q;
	logic             started_q;
	logic [1:0]       ev_q;
	logic [15:0]      pump_sec_q;
	logic             best_vld_q;
	logic signed [12:0] best_q;
	logic [4:0]       best_h_q;
	logic [5:0]       best_m_q;
	tdps_pkg::entry_t rd_ent_q;

	logic             m_tvalid_q;
	logic [tdps_pkg::OUT_DATA_W-1:0] m_tdata_q;

	logic             in_xfer;
	logic             issue_rd;
	logic             load_out;
	logic             last_rd;

	logic [1:0]       in_cmd;
	logic [31:0]      in_time;
	logic             in_valid;
	logic [4:0]       in_hr;
	logic [5:0]       in_mn;
	logic             in_dry;
	logic [7:0]       in_slot;
	tdps_pkg::entry_t in_ent;
	logic             in_ok;
	logic             in_match_en;

	tdps_pkg::entry_t ent;
	logic [10:0]      ent_min;
	logic signed [12:0] diff;
	logic signed [12:0] diff_adj;
	logic [31:0]      elapsed;
	logic             ent_hit;
	logic [1:0]       nxt_status;

	assign in_cmd         = s_tuser;
	assign in_time        = s_tdata[31:0];
	assign in_valid       = s_tdata[32];
	assign in_hr          = s_tdata[37:33];
	assign in_mn          = s_tdata[43:38];
	assign in_dry         = s_tdata[44];
	assign in_slot        = s_tdata[52:45];
	assign in_ent.hour    = s_tdata[57:53];
	assign in_ent.minute  = s_tdata[63:58];
	assign in_ent.seconds = s_tdata[79:64];
	assign in_ent.active  = s_tdata[80];

	assign in_ok       = in_slot < 8'(ENTRIES);
	assign in_match_en = (in_cmd == tdps_pkg::CMD_TICK) && !busy_q && cfg_en_q && in_valid &&
	                     ({2'b00, in_mn} != last_min_q);

	assign in_xfer = s_tvalid && s_tready;
	assign last_rd = rd_addr_q == AW'(ENTRIES - 1);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tdps_pkg::ST_IDLE: begin
				if (s_tvalid) state_nx = tdps_pkg::ST_SCAN;
			end
			tdps_pkg::ST_SCAN: begin
				if (last_rd) state_nx = tdps_pkg::ST_DRAIN;
			end
			tdps_pkg::ST_DRAIN: begin
				state_nx = tdps_pkg::ST_DONE;
			end
			tdps_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) state_nx = tdps_pkg::ST_IDLE;
			end
			default: begin
				state_nx = tdps_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		issue_rd = 1'b0;
		load_out = 1'b0;
		case (state_q)
			tdps_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			tdps_pkg::ST_SCAN: begin
				issue_rd = 1'b1;
			end
			tdps_pkg::ST_DONE: begin
				load_out = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// table memory: write at the command transfer, sweep reads afterwards
	always_ff @(posedge clk) begin
		if (in_xfer && (in_cmd == tdps_pkg::CMD_WRITE) && in_ok) begin
			mem[in_slot[AW-1:0]] <= in_ent;
		end
		rd_data_s1 <= mem[rd_addr_q];
	end

	always_comb begin
		ent      = rvld_s1 ? rd_data_s1 : '0;
		ent_min  = 11'(ent.hour) * tdps_pkg::MIN_PER_HOUR + 11'(ent.minute);
		diff     = $signed({2'b00, ent_min}) - $signed({2'b00, cur_q});
		diff_adj = (diff <= 13'sd0) ? diff + tdps_pkg::MIN_PER_DAY : diff;
		elapsed  = time_q - start_q;
		ent_hit  = match_en_q && !started_q && ent.active && dry_q &&
		           (ent.hour == hr_q) && (ent.minute == mn_q);
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q      <= in_cmd;
			time_q     <= in_time;
			hr_q       <= in_hr;
			mn_q       <= in_mn;
			dry_q      <= in_dry;
			slot_q     <= in_slot;
			ok_q       <= in_ok;
			cur_q      <= 11'(in_hr) * tdps_pkg::MIN_PER_HOUR + 11'(in_mn);
			match_en_q <= in_match_en;
		end
		idx_s1 <= rd_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdps_pkg::ST_IDLE;
			cfg_en_q    <= 1'b0;
			entry_vld_q <= '0;
			busy_q      <= 1'b0;
			start_q     <= '0;
			run_ms_q    <= '0;
			last_min_q  <= tdps_pkg::NO_MINUTE;
			stop_chk_q  <= 1'b0;
			rd_addr_q   <= '0;
			vld_s1      <= 1'b0;
			rvld_s1     <= 1'b0;
			cnt_q       <= '0;
			started_q   <= 1'b0;
			ev_q        <= tdps_pkg::EV_NONE;
			pump_sec_q  <= '0;
			best_vld_q  <= 1'b0;
			best_q      <= tdps_pkg::DIFF_NONE;
			best_h_q    <= '0;
			best_m_q    <= '0;
			rd_ent_q    <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			state_q <= state_nx;
			vld_s1  <= issue_rd;
			rvld_s1 <= entry_vld_q[rd_addr_q];

			if (cfg_we) cfg_en_q <= cfg_wdata;

			if (in_xfer) begin
				if ((in_cmd == tdps_pkg::CMD_WRITE) && in_ok) begin
					entry_vld_q[in_slot[AW-1:0]] <= 1'b1;
				end
				if (in_match_en) last_min_q <= {2'b00, in_mn};
				stop_chk_q <= (in_cmd == tdps_pkg::CMD_TICK) && busy_q;
				rd_addr_q  <= '0;
				cnt_q      <= '0;
				started_q  <= 1'b0;
				ev_q       <= tdps_pkg::EV_NONE;
				pump_sec_q <= '0;
				best_vld_q <= 1'b0;
				best_q     <= tdps_pkg::DIFF_NONE;
				best_h_q   <= '0;
				best_m_q   <= '0;
				rd_ent_q   <= '0;
			end

			if (issue_rd && !last_rd) rd_addr_q <= rd_addr_q + AW'(1);

			// stop check on the first sweep cycle
			if (stop_chk_q) begin
				stop_chk_q <= 1'b0;
				if (elapsed >= {6'd0, run_ms_q}) begin
					busy_q <= 1'b0;
					ev_q   <= tdps_pkg::EV_STOP;
				end
			end

			if (vld_s1) begin
				if (ent.active) cnt_q <= cnt_q + CW'(1);
				if (ent_hit) begin
					started_q  <= 1'b1;
					busy_q     <= 1'b1;
					start_q    <= time_q;
					run_ms_q   <= 26'(ent.seconds) * tdps_pkg::MS_PER_SEC;
					ev_q       <= tdps_pkg::EV_START;
					pump_sec_q <= ent.seconds;
				end
				if (ent.active && (diff_adj < best_q)) begin
					best_vld_q <= 1'b1;
					best_q     <= diff_adj;
					best_h_q   <= ent.hour;
					best_m_q   <= ent.minute;
				end
				if ((cmd_q == tdps_pkg::CMD_READ) && ok_q && (idx_s1 == slot_q[AW-1:0])) begin
					rd_ent_q <= ent;
				end
			end

			if (load_out) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {7'd0,
				               rd_ent_q.active, rd_ent_q.seconds,
				               rd_ent_q.minute, rd_ent_q.hour,
				               ok_q && ((cmd_q == tdps_pkg::CMD_WRITE) ||
				                        (cmd_q == tdps_pkg::CMD_READ)),
				               4'(cnt_q),
				               best_m_q & {6{nxt_status == tdps_pkg::NXT_FOUND}},
				               best_h_q & {5{nxt_status == tdps_pkg::NXT_FOUND}},
				               nxt_status, busy_q, pump_sec_q, ev_q};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign nxt_status = !cfg_en_q ? tdps_pkg::NXT_OFF :
	                    (best_vld_q ? tdps_pkg::NXT_FOUND : tdps_pkg::NXT_NONE);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ap_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (ev_q == tdps_pkg::EV_START)) |-> busy_q)
		else $error("start event without watering");

	ap_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && (ev_q == tdps_pkg::EV_STOP)) |-> !busy_q)
		else $error("stop event while watering");

	ap_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= ENTRIES)
		else $error("enabled count exceeds table size");

	ap_sweep_state: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ((state_q == tdps_pkg::ST_SCAN) || (state_q == tdps_pkg::ST_DRAIN)))
		else $error("read data outside the sweep");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the time-of-day pump scheduler: directed and random commands.
module testbench;

	localparam int SLOTS = tdps_pkg::DEF_ENTRIES;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [6:0]  fill;
		logic        slot_active;
		logic [15:0] slot_seconds;
		logic [5:0]  slot_minute;
		logic [4:0]  slot_hour;
		logic [7:0]  slot;
		logic        soil_needs_water;
		logic [5:0]  now_minute;
		logic [4:0]  now_hour;
		logic        time_valid;
		logic [31:0] time_ms;
	} sched_cmd_t;

	typedef struct packed {
		logic [6:0]  fill;
		logic        read_active;
		logic [15:0] read_seconds;
		logic [5:0]  read_minute;
		logic [4:0]  read_hour;
		logic        index_ok;
		logic [3:0]  enabled_count;
		logic [5:0]  next_minute;
		logic [4:0]  next_hour;
		logic [1:0]  next_status;
		logic        watering;
		logic [15:0] pump_seconds;
		logic [1:0]  pump_event;
	} sched_report_t;

	class pump_schedule_tracker;
		tdps_pkg::entry_t alarms[SLOTS];
		bit            enabled;
		bit            busy;
		logic [31:0]   start_ms;
		logic [15:0]   run_secs;
		logic [7:0]    last_minute;
		sched_report_t expected_reports[$];
		int            errors;
		int            commands;
		int            starts;
		int            stops;
		int            writes;
		int            reads;

		function new();
			foreach (alarms[i]) alarms[i] = '0;
			enabled = 0;
			busy = 0;
			start_ms = '0;
			run_secs = '0;
			last_minute = tdps_pkg::NO_MINUTE;
			errors = 0;
			commands = 0;
			starts = 0;
			stops = 0;
			writes = 0;
			reads = 0;
		endfunction

		function void note_command(logic [1:0] cmd, sched_cmd_t c);
			sched_report_t     r;
			logic              ok;
			logic              started;
			logic [SLOT_W-1:0] idx;
			int                best_diff;
			int                best;
			int                cur;
			int                diff;
			int                count;
			r = '0;
			ok = c.slot < SLOTS;
			idx = c.slot[SLOT_W-1:0];
			started = 0;
			commands++;
			case (cmd)
				tdps_pkg::CMD_TICK: begin
					if (busy) begin
						if (c.time_ms - start_ms >= {16'd0, run_secs} * 32'd1000) begin
							busy = 0;
							r.pump_event = tdps_pkg::EV_STOP;
							stops++;
						end
					end else if (enabled && c.time_valid &&
							{2'b00, c.now_minute} != last_minute) begin
						last_minute = {2'b00, c.now_minute};
						for (int i = 0; i < SLOTS; i++) begin
							if (!started && alarms[i].active && alarms[i].hour == c.now_hour &&
									alarms[i].minute == c.now_minute && c.soil_needs_water) begin
								started = 1;
								run_secs = alarms[i].seconds;
								start_ms = c.time_ms;
								busy = 1;
								r.pump_event = tdps_pkg::EV_START;
								r.pump_seconds = alarms[i].seconds;
								starts++;
							end
						end
					end
				end
				tdps_pkg::CMD_WRITE: begin
					writes++;
					if (ok) begin
						alarms[idx].hour = c.slot_hour;
						alarms[idx].minute = c.slot_minute;
						alarms[idx].seconds = c.slot_seconds;
						alarms[idx].active = c.slot_active;
					end
					r.index_ok = ok;
				end
				tdps_pkg::CMD_READ: begin
					reads++;
					if (ok) begin
						r.read_hour = alarms[idx].hour;
						r.read_minute = alarms[idx].minute;
						r.read_seconds = alarms[idx].seconds;
						r.read_active = alarms[idx].active;
					end
					r.index_ok = ok;
				end
				default: begin
				end
			endcase
			r.watering = busy;
			if (!enabled) begin
				r.next_status = tdps_pkg::NXT_OFF;
			end else begin
				best_diff = 1441;
				best = -1;
				cur = int'(c.now_hour) * 60 + int'(c.now_minute);
				for (int i = 0; i < SLOTS; i++) begin
					if (alarms[i].active) begin
						diff = int'(alarms[i].hour) * 60 + int'(alarms[i].minute) - cur;
						if (diff <= 0)
							diff += 1440;
						if (diff < best_diff) begin
							best_diff = diff;
							best = i;
						end
					end
				end
				if (best >= 0) begin
					r.next_status = tdps_pkg::NXT_FOUND;
					r.next_hour = alarms[best].hour;
					r.next_minute = alarms[best].minute;
				end else begin
					r.next_status = tdps_pkg::NXT_NONE;
				end
			end
			count = 0;
			foreach (alarms[i])
				if (alarms[i].active)
					count++;
			r.enabled_count = 4'(count);
			expected_reports.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(sched_report_t got);
			sched_report_t want;
			if (expected_reports.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result, expected none, got %h", $time, got);
				return;
			end
			want = expected_reports.pop_front();
			compare_field("pump_event", want.pump_event, got.pump_event);
			compare_field("pump_seconds", want.pump_seconds, got.pump_seconds);
			compare_field("watering", want.watering, got.watering);
			compare_field("next_status", want.next_status, got.next_status);
			compare_field("next_hour", want.next_hour, got.next_hour);
			compare_field("next_minute", want.next_minute, got.next_minute);
			compare_field("enabled_count", want.enabled_count, got.enabled_count);
			compare_field("index_ok", want.index_ok, got.index_ok);
			compare_field("read_hour", want.read_hour, got.read_hour);
			compare_field("read_minute", want.read_minute, got.read_minute);
			compare_field("read_seconds", want.read_seconds, got.read_seconds);
			compare_field("read_active", want.read_active, got.read_active);
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic                            cfg_wdata;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [tdps_pkg::IN_DATA_W-1:0]  s_tdata;
	logic [1:0]                      s_tuser;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [tdps_pkg::OUT_DATA_W-1:0] m_tdata;

	pump_schedule_tracker schedule = new();
	int burst_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int stall_phase = 0;

	time_of_day_pump_scheduler uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left <= $urandom_range(50, 400);
		end else begin
			mode_left <= mode_left - 1;
		end
		stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (stall_phase < 3);
		endcase
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			schedule.check_result(m_tdata);

	function automatic sched_cmd_t scramble();
		sched_cmd_t c;
		c = {$urandom, $urandom, 24'($urandom)};
		c.fill = '0;
		return c;
	endfunction

	function automatic sched_cmd_t tick_item(logic [31:0] ms, logic valid, logic [4:0] hr,
			logic [5:0] mn, logic dry);
		sched_cmd_t c;
		c = scramble();
		c.time_ms = ms;
		c.time_valid = valid;
		c.now_hour = hr;
		c.now_minute = mn;
		c.soil_needs_water = dry;
		return c;
	endfunction

	function automatic sched_cmd_t entry_item(logic [7:0] slot, logic [4:0] hr, logic [5:0] mn,
			logic [15:0] secs, logic act);
		sched_cmd_t c;
		c = scramble();
		c.slot = slot;
		c.slot_hour = hr;
		c.slot_minute = mn;
		c.slot_seconds = secs;
		c.slot_active = act;
		return c;
	endfunction

	task automatic send_command(input logic [1:0] cmd, input sched_cmd_t item);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 16);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= item;
		s_tuser <= cmd;
		do @(posedge clk); while (!s_tready);
		schedule.note_command(cmd, item);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (schedule.expected_reports.size() != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 8) @(posedge clk);
	endtask

	task automatic set_enable(input logic value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		schedule.enabled = value;
		@(posedge clk);
	endtask

	task automatic run_phase(input int count);
		logic [31:0] ms;
		logic [4:0]  base_hour;
		logic [5:0]  mn;
		logic [15:0] secs;
		logic [7:0]  slot;
		int          pick;
		ms = $urandom;
		base_hour = 5'($urandom_range(0, 23));
		mn = 6'd0;
		for (int i = 0; i < SLOTS; i++) begin
			secs = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
			send_command(tdps_pkg::CMD_WRITE, entry_item(8'(i), base_hour,
				6'($urandom_range(0, 11)), secs, $urandom_range(0, 4) != 0));
		end
		repeat (count) begin
			pick = $urandom_range(0, 99);
			slot = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
			if (pick < 70) begin
				ms += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2500);
				if ($urandom_range(0, 1))
					mn = (mn == 6'd11) ? 6'd0 : mn + 6'd1;
				send_command(tdps_pkg::CMD_TICK, tick_item(ms, $urandom_range(0, 19) != 0,
					base_hour, mn, $urandom_range(0, 4) != 0));
			end else if (pick < 80) begin
				secs = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
				send_command(tdps_pkg::CMD_WRITE, entry_item(slot,
					$urandom_range(0, 3) == 0 ? 5'($urandom) : base_hour,
					$urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 11)),
					secs, $urandom_range(0, 3) != 0));
			end else if (pick < 90) begin
				send_command(tdps_pkg::CMD_READ, entry_item(slot, 5'($urandom), 6'($urandom),
					16'($urandom), 1'($urandom)));
			end else if (pick < 93) begin
				send_command(CMD_SPARE, scramble());
			end else begin
				send_command(2'($urandom_range(0, 2)), scramble());
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= tdps_pkg::CMD_TICK;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(tdps_pkg::CMD_READ, entry_item(8'd0, 5'd1, 6'd1, 16'd1, 1'b1));
		send_command(tdps_pkg::CMD_READ, entry_item(8'd255, 5'd1, 6'd1, 16'd1, 1'b1));
		send_command(tdps_pkg::CMD_TICK, tick_item(32'h0000_0500, 1'b1, 5'd6, 6'd31, 1'b1));
		send_command(CMD_SPARE, scramble());
		send_command(tdps_pkg::CMD_WRITE, entry_item(8'd0, 5'd6, 6'd30, 16'd0, 1'b1));
		send_command(tdps_pkg::CMD_WRITE, entry_item(8'd1, 5'd6, 6'd31, 16'd2, 1'b1));
		send_command(tdps_pkg::CMD_WRITE, entry_item(8'd7, 5'd23, 6'd59, 16'hFFFF, 1'b1));
		send_command(tdps_pkg::CMD_WRITE, entry_item(8'd8, 5'd1, 6'd1, 16'd100, 1'b1));
		send_command(tdps_pkg::CMD_WRITE, entry_item(8'd2, 5'd31, 6'd63, 16'hFFFF, 1'b1));
		set_enable(1'b1);
		send_command(tdps_pkg::CMD_TICK, tick_item(32'h0000_0800, 1'b0, 5'd6, 6'd31, 1'b1));
		send_command(tdps_pkg::CMD_TICK, tick_item(32'h0000_0900, 1'b1, 5'd6, 6'd30, 1'b0));
		send_command(tdps_pkg::CMD_TICK, tick_item(32'h0000_0A00, 1'b1, 5'd6, 6'd30, 1'b1));
		send_command(tdps_pkg::CMD_TICK, tick_item(32'h0000_1000, 1'b1, 5'd6, 6'd31, 1'b1));
		send_command(tdps_pkg::CMD_TICK,
			tick_item(32'h0000_1000 + 1999, 1'b1, 5'd6, 6'd31, 1'b1));
		send_command(tdps_pkg::CMD_TICK,
			tick_item(32'h0000_1000 + 2000, 1'b1, 5'd6, 6'd31, 1'b1));
		send_command(tdps_pkg::CMD_TICK, tick_item(32'h0000_2000, 1'b1, 5'd6, 6'd30, 1'b1));
		send_command(tdps_pkg::CMD_TICK, tick_item(32'h0000_2000, 1'b1, 5'd6, 6'd30, 1'b1));
		send_command(tdps_pkg::CMD_TICK, tick_item(32'hFFFF_FF00, 1'b1, 5'd23, 6'd59, 1'b1));
		send_command(tdps_pkg::CMD_TICK, tick_item(32'h0000_0100, 1'b1, 5'd0, 6'd0, 1'b1));
		set_enable(1'b0);
		send_command(tdps_pkg::CMD_TICK,
			tick_item(32'hFFFF_FF00 + 32'd65535000, 1'b1, 5'd0, 6'd1, 1'b1));
		send_command(tdps_pkg::CMD_TICK, tick_item(32'h0001_0000, 1'b1, 5'd31, 6'd63, 1'b1));
		send_command(tdps_pkg::CMD_READ, entry_item(8'd7, 5'd0, 6'd0, 16'd0, 1'b0));
		send_command(tdps_pkg::CMD_READ, entry_item(8'd2, 5'd0, 6'd0, 16'd0, 1'b0));
		send_command(tdps_pkg::CMD_WRITE, entry_item(8'd7, 5'd0, 6'd0, 16'd0, 1'b0));
		set_enable(1'b1);
		send_command(tdps_pkg::CMD_TICK, tick_item(32'h0002_0000, 1'b0, 5'd31, 6'd63, 1'b1));

		for (int p = 0; p < 6; p++) begin
			set_enable(p != 1 && p != 4);
			run_phase(320);
		end

		drain();
		$display("Ran %0d commands: %0d writes, %0d reads, %0d pump starts, %0d pump stops,",
			schedule.commands, schedule.writes, schedule.reads, schedule.starts, schedule.stops);
		$display("over directed corner cases and six random phases with the scheduler on and off");
		if (schedule.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
design/tdps_pkg.sv
design/time_of_day_pump_scheduler.sv
tb/testbench.sv
